### sv/sensor_reply_frame_parser_defines.svh
// Assertion macros shared by the checker of the sensor reply frame parser.
// No dependencies; included by the checker file.
`ifndef SENSOR_REPLY_FRAME_PARSER_DEFINES_SVH
`define SENSOR_REPLY_FRAME_PARSER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define SRFP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent at an edge implies consequent at the same edge.
`define SRFP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent at an edge implies consequent at the next edge.
`define SRFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/srfp_pkg.sv
// Types and constants of the sensor reply frame parser.
// No dependencies; used by the interfaces, the core and the top level.
package srfp_pkg;

  localparam int ModeW    = 2;
  localparam int ByteW    = 8;
  localparam int OutcomeW = 2;
  localparam int FlagsW   = 2;
  localparam int ReadingW = 15;
  localparam int TicksW   = 16;

  // Item kinds
  localparam logic [ModeW-1:0] MODE_BYTE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_TICK  = 2'd1;
  localparam logic [ModeW-1:0] MODE_START = 2'd2;
  localparam logic [ModeW-1:0] MODE_NONE  = 2'd3;

  // Result codes
  localparam logic [OutcomeW-1:0] OUT_GOOD     = 2'd0;
  localparam logic [OutcomeW-1:0] OUT_CHECKSUM = 2'd1;
  localparam logic [OutcomeW-1:0] OUT_HEADER   = 2'd2;
  localparam logic [OutcomeW-1:0] OUT_TIMEOUT  = 2'd3;

  // Frame constants
  localparam logic [ByteW-1:0] SYNC_BYTE   = 8'h02;
  localparam logic [ByteW-1:0] HDR1_BYTE   = 8'h10;
  localparam logic [ByteW-1:0] HDR2_BYTE   = 8'h04;
  localparam logic [ByteW-1:0] SUM_GOOD    = 8'hFF;
  localparam logic [ReadingW-1:0] VALUE_SCALE = 15'd100;
  localparam logic [ReadingW-1:0] READING_MAX = 15'd25755;

  localparam logic [TicksW-1:0] TIMEOUT_RESET = 16'd20000;
  localparam logic [TicksW-1:0] TICKS_MAX     = 16'hFFFF;

  // Position in the reply frame
  typedef enum logic [2:0] {
    PH_SYNC   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_HDR2   = 3'd2,
    PH_STATUS = 3'd3,
    PH_UPTIME = 3'd4,
    PH_VAL_HI = 3'd5,
    PH_VAL_LO = 3'd6,
    PH_CHECK  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic                ready_res;
    logic [ByteW-1:0]    status_byte;
    logic [FlagsW-1:0]   up_flags;
    logic [ByteW-1:0]    uptime_byte;
    logic [ReadingW-1:0] reading;
  } res_t;

endpackage

### sv/srfp_item_if.sv
// Input channel of the sensor reply frame parser: valid/ready plus one item.
// Depends on srfp_pkg for field widths.
interface srfp_item_if;
  logic                             valid;
  logic                             ready;
  logic [srfp_pkg::ModeW-1:0]       mode;
  logic [srfp_pkg::ByteW-1:0]       rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

### sv/srfp_result_if.sv
// Result channel of the sensor reply frame parser: valid/ready plus one result.
// Depends on srfp_pkg for field widths.
interface srfp_result_if;
  logic                               valid;
  logic                               ready;
  logic [srfp_pkg::OutcomeW-1:0]      outcome;
  logic                               ready_res;
  logic [srfp_pkg::ByteW-1:0]         status_byte;
  logic [srfp_pkg::FlagsW-1:0]        up_flags;
  logic [srfp_pkg::ByteW-1:0]         uptime_byte;
  logic [srfp_pkg::ReadingW-1:0]      reading;

  modport source (output valid, output outcome, output ready_res, output status_byte,
                  output up_flags, output uptime_byte, output reading, input ready);
  modport sink   (input valid, input outcome, input ready_res, input status_byte,
                  input up_flags, input uptime_byte, input reading, output ready);
endinterface

### sv/sensor_reply_frame_parser.sv
// Top level of the sensor reply frame parser: input register, result register,
// timeout register. Depends on srfp_pkg, srfp_item_if, srfp_result_if, srfp_core.
//
//   channel   | dir | contents
//   ----------+-----+------------------------------------------
//   item      | in  | mode, rx_byte
//   result    | out | outcome, ready_res, status_byte, up_flags,
//             |     | uptime_byte, reading
//   timeout_* | in  | timeout_ticks register write (we, wdata)
//
// One item per cycle while the result is not stalled. An accepted item passes
// the input register; its result (if any) then lands in the result register.
// The input register advances whenever the result register is empty or being
// drained, so a stalled result holds back at most one item.
// Reset clears the valid flags and the core's parser state and loads the timeout register with 20000.
module sensor_reply_frame_parser (
  input  logic                        clk,
  input  logic                        rst,
  srfp_item_if.sink                   item,
  srfp_result_if.source               result,
  input  logic                        timeout_we,
  input  logic [srfp_pkg::TicksW-1:0] timeout_wdata
);

  logic                          s_valid;
  logic [srfp_pkg::ModeW-1:0]    s_mode;
  logic [srfp_pkg::ByteW-1:0]    s_byte;
  logic                          o_valid;
  srfp_pkg::res_t                o_res;
  logic [srfp_pkg::TicksW-1:0]   timeout_ticks;
  logic                          advance;
  logic                          res_fire;
  srfp_pkg::res_t                res;

  assign advance    = s_valid && (!o_valid || result.ready);
  assign item.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= srfp_pkg::TIMEOUT_RESET;
    end else if (timeout_we) begin
      timeout_ticks <= timeout_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item.ready) begin
      s_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s_mode <= item.mode;
      s_byte <= item.rx_byte;
    end
  end

  srfp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .mode          (s_mode),
    .rx_byte       (s_byte),
    .timeout_ticks (timeout_ticks),
    .res_fire      (res_fire),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= res_fire;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      o_res <= res;
    end
  end

  assign result.valid       = o_valid;
  assign result.outcome     = o_res.outcome;
  assign result.ready_res   = o_res.ready_res;
  assign result.status_byte = o_res.status_byte;
  assign result.up_flags    = o_res.up_flags;
  assign result.uptime_byte = o_res.uptime_byte;
  assign result.reading     = o_res.reading;

endmodule

### sv/srfp_core.sv
// Frame parsing state machine: phase, checksum, held fields and tick counter.
// Depends on srfp_pkg; instantiated by sensor_reply_frame_parser.
module srfp_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [srfp_pkg::ModeW-1:0]        mode,
  input  logic [srfp_pkg::ByteW-1:0]        rx_byte,
  input  logic [srfp_pkg::TicksW-1:0]       timeout_ticks,
  output logic                              res_fire,
  output srfp_pkg::res_t                    res
);

  logic                           busy, busy_next;
  srfp_pkg::phase_t               phase, phase_next;
  logic [srfp_pkg::ByteW-1:0]     running_sum, running_sum_next;
  logic [srfp_pkg::ByteW-1:0]     held_status, held_status_next;
  logic [srfp_pkg::ByteW-1:0]     held_uptime, held_uptime_next;
  logic [srfp_pkg::ReadingW-1:0]  held_reading, held_reading_next;
  logic [srfp_pkg::TicksW-1:0]    tick_count, tick_count_next;

  logic [srfp_pkg::ByteW-1:0]     sum_add;
  logic [srfp_pkg::TicksW-1:0]    tick_inc;
  logic [srfp_pkg::OutcomeW-1:0]  code;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      phase        <= srfp_pkg::PH_SYNC;
      running_sum  <= '0;
      held_status  <= '0;
      held_uptime  <= '0;
      held_reading <= '0;
      tick_count   <= '0;
    end else if (step) begin
      busy         <= busy_next;
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      held_status  <= held_status_next;
      held_uptime  <= held_uptime_next;
      held_reading <= held_reading_next;
      tick_count   <= tick_count_next;
    end
  end

  assign sum_add  = running_sum + rx_byte;
  assign tick_inc = (tick_count == srfp_pkg::TICKS_MAX) ? tick_count
                                                        : tick_count + 16'd1;

  always_comb begin
    busy_next         = busy;
    phase_next        = phase;
    running_sum_next  = running_sum;
    held_status_next  = held_status;
    held_uptime_next  = held_uptime;
    held_reading_next = held_reading;
    tick_count_next   = tick_count;
    res_fire          = 1'b0;
    code              = srfp_pkg::OUT_GOOD;

    unique case (mode)
      srfp_pkg::MODE_START: begin
        busy_next       = 1'b1;
        phase_next      = srfp_pkg::PH_SYNC;
        tick_count_next = '0;
      end
      srfp_pkg::MODE_TICK: begin
        if (busy) begin
          tick_count_next = tick_inc;
          if (tick_inc > timeout_ticks) begin
            res_fire = 1'b1;
            code     = srfp_pkg::OUT_TIMEOUT;
          end
        end
      end
      srfp_pkg::MODE_BYTE: begin
        if (busy) begin
          running_sum_next = sum_add;
          phase_next       = srfp_pkg::phase_t'(phase + 3'd1);
          unique case (phase)
            srfp_pkg::PH_SYNC: begin
              // skip anything before the sync byte
              running_sum_next = '0;
              phase_next = (rx_byte == srfp_pkg::SYNC_BYTE) ? srfp_pkg::PH_HDR1
                                                            : srfp_pkg::PH_SYNC;
            end
            srfp_pkg::PH_HDR1: begin
              if (rx_byte != srfp_pkg::HDR1_BYTE) begin
                res_fire = 1'b1;
                code     = srfp_pkg::OUT_HEADER;
              end
            end
            srfp_pkg::PH_HDR2: begin
              if (rx_byte != srfp_pkg::HDR2_BYTE) begin
                res_fire = 1'b1;
                code     = srfp_pkg::OUT_HEADER;
              end
            end
            srfp_pkg::PH_STATUS: held_status_next = rx_byte;
            srfp_pkg::PH_UPTIME: held_uptime_next = rx_byte;
            srfp_pkg::PH_VAL_HI: begin
              held_reading_next = srfp_pkg::ReadingW'(rx_byte) * srfp_pkg::VALUE_SCALE;
            end
            srfp_pkg::PH_VAL_LO: begin
              held_reading_next = held_reading + srfp_pkg::ReadingW'(rx_byte);
            end
            srfp_pkg::PH_CHECK: begin
              res_fire = 1'b1;
              code = (sum_add == srfp_pkg::SUM_GOOD) ? srfp_pkg::OUT_GOOD
                                                     : srfp_pkg::OUT_CHECKSUM;
            end
            default: phase_next = srfp_pkg::PH_SYNC;
          endcase
        end
      end
      default: ;  // unused item kind: drop
    endcase

    // close the transaction on any result
    if (res_fire) begin
      busy_next  = 1'b0;
      phase_next = srfp_pkg::PH_SYNC;
    end
  end

  // result fields carry the held values as they stand before this item
  always_comb begin
    res.outcome     = code;
    res.ready_res   = (code == srfp_pkg::OUT_GOOD);
    res.status_byte = held_status;
    res.up_flags    = held_status[srfp_pkg::FlagsW-1:0];
    res.uptime_byte = held_uptime;
    res.reading     = held_reading;
  end

endmodule

### sv/srfp_checker.sv
// Port-level checks on the result channel of the sensor reply frame parser.
// Depends on srfp_pkg and sensor_reply_frame_parser_defines.svh; bound to the top.
`include "sensor_reply_frame_parser_defines.svh"

module srfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [srfp_pkg::OutcomeW-1:0] outcome,
  input logic                          ready_res,
  input logic [srfp_pkg::ByteW-1:0]    status_byte,
  input logic [srfp_pkg::FlagsW-1:0]   up_flags,
  input logic [srfp_pkg::ReadingW-1:0] reading
);

  `SRFP_ASSERT_NEXT(a_valid_holds, clk, rst, res_valid && !res_ready, res_valid)
  `SRFP_ASSERT_IMPLIES(a_ready_res_good, clk, rst, res_valid, ready_res == (outcome == srfp_pkg::OUT_GOOD))
  `SRFP_ASSERT_IMPLIES(a_flags_match, clk, rst, res_valid, up_flags == status_byte[srfp_pkg::FlagsW-1:0])
  `SRFP_ASSERT_IMPLIES(a_reading_range, clk, rst, res_valid, reading <= srfp_pkg::READING_MAX)
  `SRFP_ASSERT_IMPLIES(a_quiet_after_reset, clk, rst, $past(rst), !res_valid)

endmodule

bind sensor_reply_frame_parser srfp_checker u_srfp_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .outcome     (result.outcome),
  .ready_res   (result.ready_res),
  .status_byte (result.status_byte),
  .up_flags    (result.up_flags),
  .reading     (result.reading)
);
